// ----- rtl/pmfa_pkg.sv -----
// pmfa_pkg: shared types, codes and default sizes for the paged frame allocator
// no dependencies; used by paged_mmu_frame_allocator
package pmfa_pkg;

  // default sizes; PAGE_BYTES is a power of two
  localparam int unsigned PageBytesDef  = 512;
  localparam int unsigned InstrPagesDef = 2;
  localparam int unsigned DataPagesDef  = 2;
  localparam int unsigned FramesDef     = 64;
  localparam int unsigned ProcsDef      = 4;

  localparam logic [7:0] ByteMask = 8'hFF;

  // request kinds
  localparam logic [2:0] KIND_MAP     = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_RD_BYTE = 3'd2;
  localparam logic [2:0] KIND_WR_BYTE = 3'd3;
  localparam logic [2:0] KIND_RD_WORD = 3'd4;
  localparam logic [2:0] KIND_WR_WORD = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FAULT = 2'd1;
  localparam logic [1:0] STAT_OOF   = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  proc;
    logic        space;
    logic [1:0]  page;
    logic [15:0] address;
    logic [31:0] value;
  } pmfa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [7:0]  frame;
  } pmfa_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_REL,
    S_ACC,
    S_RDW,
    S_DONE
  } pmfa_state_e;

endpackage

// ----- rtl/pmfa_ram.sv -----
// pmfa_ram: generic single-port ram with registered read data
// no dependencies
module pmfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/paged_mmu_frame_allocator.sv -----
// paged_mmu_frame_allocator: per-process page tables, free-frame map, byte store
// depends on pmfa_pkg and pmfa_ram (byte store)
// map scans for a free frame, then zero-fills the page; with no free frame it
//   releases every page of the process; release frees all pages of the process;
//   one item at a time: the input stalls until the result has been pushed out
// reset clears page tables and the frame map (frame 0 stays reserved); the byte store is not swept, since
//   every frame is zero-filled when it is mapped and before it can be read
module paged_mmu_frame_allocator #(
  parameter int unsigned PAGE_BYTES  = pmfa_pkg::PageBytesDef,
  parameter int unsigned INSTR_PAGES = pmfa_pkg::InstrPagesDef,
  parameter int unsigned DATA_PAGES  = pmfa_pkg::DataPagesDef,
  parameter int unsigned FRAMES      = pmfa_pkg::FramesDef,
  parameter int unsigned PROCS       = pmfa_pkg::ProcsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pmfa_pkg::pmfa_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pmfa_pkg::pmfa_out_t out_o
);
  import pmfa_pkg::*;

  localparam int unsigned SLOTS = INSTR_PAGES + DATA_PAGES;
  localparam int unsigned PT_N  = PROCS * SLOTS;
  localparam int unsigned PT_W  = (PT_N > 1) ? $clog2(PT_N) : 1;
  localparam int unsigned SL_W  = $clog2(SLOTS);
  localparam int unsigned PB_W  = $clog2(PAGE_BYTES);
  localparam int unsigned FR_W  = $clog2(FRAMES);
  localparam int unsigned RAM_D = FRAMES * PAGE_BYTES;
  localparam int unsigned RA_W  = $clog2(RAM_D);
  localparam logic [16:0] IBound = 17'(INSTR_PAGES * PAGE_BYTES);
  localparam logic [16:0] DBound = 17'(DATA_PAGES * PAGE_BYTES);

  pmfa_state_e state_q, state_d;
  pmfa_in_t    req_q, req_d;
  pmfa_out_t   res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  k_q, k_d;
  logic [FR_W-1:0] scan_q, scan_d, frame_q, frame_d;
  logic [PB_W-1:0] fill_q, fill_d;
  logic [SL_W-1:0] slot_q, slot_d;
  logic [31:0] word_q, word_d;
  logic [FRAMES-1:0] used_q, used_d;
  logic [7:0] pt_q [PT_N];
  logic [7:0] pt_d [PT_N];

  logic            ram_en, ram_we;
  logic [RA_W-1:0] ram_addr;
  logic [7:0]      ram_wdata, ram_rdata;

  logic accept, push, is_word, is_write, last_k;
  logic [16:0]     tr_vaddr, tr_bound, tr_slot;
  logic            tr_instr, tr_fault;
  logic [PT_W-1:0] tr_idx, map_idx, rel_idx;
  logic [7:0]      tr_frame, rel_frame;
  logic [RA_W-1:0] tr_phys;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign push       = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign is_word  = (req_q.kind == KIND_RD_WORD) || (req_q.kind == KIND_WR_WORD);
  assign is_write = (req_q.kind == KIND_WR_BYTE) || (req_q.kind == KIND_WR_WORD);
  assign last_k   = is_word ? (k_q == 2'd3) : 1'b1;

  // translation of byte k of the current access
  assign tr_instr = is_word ? 1'b0 : req_q.space;
  assign tr_vaddr = {1'b0, req_q.address} + 17'(k_q);
  assign tr_bound = tr_instr ? IBound : DBound;
  assign tr_slot  = (tr_vaddr >> PB_W) + (tr_instr ? 17'd0 : 17'(INSTR_PAGES));
  assign tr_idx   = PT_W'(int'(req_q.proc) * SLOTS + int'(tr_slot));
  assign tr_frame = pt_q[tr_idx];
  assign tr_fault = (tr_vaddr >= tr_bound) || (tr_slot >= 17'(SLOTS)) ||
                    (tr_frame == 8'd0) || ({1'b0, tr_frame} >= 9'(FRAMES));
  assign tr_phys  = {tr_frame[FR_W-1:0], tr_vaddr[PB_W-1:0]};

  assign map_idx   = PT_W'(int'(req_q.proc) * SLOTS + int'(req_q.page));
  assign rel_idx   = PT_W'(int'(req_q.proc) * SLOTS + int'(slot_q));
  assign rel_frame = pt_q[rel_idx];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (32'(in_i.proc) >= PROCS) begin
            state_d = S_DONE;
          end else begin
            case (in_i.kind)
              KIND_MAP:     state_d = (32'(in_i.page) < SLOTS) ? S_SCAN : S_DONE;
              KIND_RELEASE: state_d = S_REL;
              KIND_RD_BYTE, KIND_WR_BYTE, KIND_RD_WORD, KIND_WR_WORD: state_d = S_ACC;
              default:      state_d = S_DONE;
            endcase
          end
        end
      end
      S_SCAN: begin
        if (!used_q[scan_q]) begin
          state_d = S_FILL;
        end else if (scan_q == FR_W'(FRAMES - 1)) begin
          state_d = S_REL;
        end
      end
      S_FILL: begin
        if (&fill_q) state_d = S_DONE;
      end
      S_REL: begin
        if (slot_q == SL_W'(SLOTS - 1)) state_d = S_DONE;
      end
      S_ACC: begin
        if (tr_fault) begin
          state_d = S_DONE;
        end else if (!is_write) begin
          state_d = S_RDW;
        end else if (last_k) begin
          state_d = S_DONE;
        end
      end
      S_RDW: begin
        state_d = last_k ? S_DONE : S_ACC;
      end
      S_DONE: begin
        if (push) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and table updates
  always_comb begin
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    k_d         = k_q;
    scan_d      = scan_q;
    frame_d     = frame_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    word_d      = word_q;
    used_d      = used_q;
    pt_d        = pt_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = tr_phys;
    ram_wdata   = 8'd0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d  = in_i;
          k_d    = 2'd0;
          scan_d = FR_W'(1);
          fill_d = '0;
          slot_d = '0;
          word_d = 32'd0;
          res_d  = '{status: STAT_FAULT, data: 32'd0, frame: 8'd0};
          if (in_i.kind == KIND_RELEASE) res_d.status = STAT_OK;
        end
      end
      S_SCAN: begin
        if (!used_q[scan_q]) begin
          used_d[scan_q] = 1'b1;
          pt_d[map_idx]  = 8'(scan_q);
          frame_d        = scan_q;
        end else if (scan_q == FR_W'(FRAMES - 1)) begin
          res_d.status = STAT_OOF;   // out of frames: drop the whole process
        end else begin
          scan_d = scan_q + FR_W'(1);
        end
      end
      S_FILL: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = {frame_q, fill_q};
        fill_d   = fill_q + PB_W'(1);
        if (&fill_q) res_d = '{status: STAT_OK, data: 32'd0, frame: 8'(frame_q)};
      end
      S_REL: begin
        if (rel_frame != 8'd0) begin
          if ({1'b0, rel_frame} < 9'(FRAMES)) used_d[rel_frame[FR_W-1:0]] = 1'b0;
          pt_d[rel_idx] = 8'd0;
        end
        slot_d = slot_q + SL_W'(1);
      end
      S_ACC: begin
        if (tr_fault) begin
          res_d.status = STAT_FAULT;
          res_d.data   = 32'd0;
        end else begin
          ram_en    = 1'b1;
          ram_we    = is_write;
          ram_wdata = 8'(req_q.value >> (5'd8 * 5'(k_q))) & ByteMask;
          if (is_write) begin
            k_d = k_q + 2'd1;
            if (last_k) res_d = '{status: STAT_OK, data: 32'd0, frame: 8'd0};
          end
        end
      end
      S_RDW: begin
        word_d = word_q | (32'(ram_rdata) << (5'd8 * 5'(k_q)));
        k_d    = k_q + 2'd1;
        if (last_k) res_d = '{status: STAT_OK, data: word_d, frame: 8'd0};
      end
      S_DONE: begin
        if (push) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= FRAMES'(1);
      for (int i = 0; i < PT_N; i++) pt_q[i] <= 8'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      pt_q        <= pt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    res_q   <= res_d;
    out_q   <= out_d;
    k_q     <= k_d;
    scan_q  <= scan_d;
    frame_q <= frame_d;
    fill_q  <= fill_d;
    slot_q  <= slot_d;
    word_q  <= word_d;
  end

  pmfa_ram #(
    .WIDTH (8),
    .DEPTH (RAM_D)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_frame0_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q[0]) else $error("frame 0 marked free");

  a_no_write_frame0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_en && ram_we) |-> (ram_addr[RA_W-1:PB_W] != '0))
    else $error("store write into reserved frame");

  a_oof_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == STAT_OOF) |-> (out_o.frame == 8'd0 && out_o.data == 32'd0))
    else $error("out of frames word carries data");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE)) else $error("accepted word not processed");

  a_fill_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> used_q[frame_q]) else $error("filling a free frame");

endmodule
